// ===== sv/apg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apg_pkg
// Shared widths, constants and the CORDIC arctangent table for the arc
// point generator.
// ----------------------------------------------------------------------------
package apg_pkg;

  localparam int MAX_POINTS   = 64;
  localparam int CORDIC_STEPS = 24;

  localparam int COORD_W = 32;              // Q16.16 coordinate
  localparam int VEC_W   = 52;              // guarded CORDIC x/y
  localparam int ANG_W   = 32;              // fraction of a turn
  localparam int Z_W     = 34;              // CORDIC angle accumulator
  localparam int ITER_W  = 5;               // index into the 32-entry table
  localparam int CNT_W   = 7;               // point count register
  localparam int IDX_W   = 6;               // point index
  localparam int DIV_W   = 6;               // divisor (point count - 1)
  localparam int SWP_W   = 33;              // swept angle, up to a full turn
  localparam int GAIN_W  = 30;

  localparam logic [CNT_W-1:0]  POINT_COUNT_RST = 7'd16;
  localparam logic [GAIN_W-1:0] INV_GAIN        = 30'd652032875;

  localparam logic [29:0] ATAN_TURN [32] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
    30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
    30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
    30'd652,       30'd326,       30'd163,       30'd81,       30'd41,
    30'd20,        30'd10,        30'd5,         30'd3,        30'd1,
    30'd1,         30'd0
  };

  typedef struct packed {
    logic start;
    logic vectoring;   // 1: drive y to zero, 0: rotate by z
  } cordic_ctl_t;

endpackage

// ===== sv/apg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apg_if
// Valid/ready channels of the arc point generator: arc requests, emitted
// points and the point count register write.
// ----------------------------------------------------------------------------
interface apg_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] centre_x;
  logic signed [31:0] centre_y;
  logic               clockwise;
  modport source (output valid, start_x, start_y, end_x, end_y, centre_x, centre_y,
                  clockwise, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, centre_x, centre_y,
                  clockwise, output ready);
endinterface

interface apg_pt_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic [5:0]         point_index;
  logic               last_point;
  modport source (output valid, point_x, point_y, point_index, last_point, input ready);
  modport sink   (input valid, point_x, point_y, point_index, last_point, output ready);
endinterface

interface apg_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== sv/apg_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apg_cordic
// Iterative CORDIC: one micro-rotation per cycle, vectoring or rotation.
// ----------------------------------------------------------------------------
module apg_cordic (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  apg_pkg::cordic_ctl_t             ctl_i,
  input  logic signed [apg_pkg::VEC_W-1:0] x0_i,
  input  logic signed [apg_pkg::VEC_W-1:0] y0_i,
  input  logic signed [apg_pkg::Z_W-1:0]   z0_i,
  output logic signed [apg_pkg::VEC_W-1:0] x_o,
  output logic signed [apg_pkg::VEC_W-1:0] y_o,
  output logic signed [apg_pkg::Z_W-1:0]   z_o,
  output logic                             done_o
);
  import apg_pkg::*;

  logic signed [VEC_W-1:0] x_q, y_q, xs, ys;
  logic signed [Z_W-1:0]   z_q, atan_z;
  logic [ITER_W-1:0]       iter_q;
  logic                    busy_q, vec_q, done_q, dir;

  assign xs     = x_q >>> iter_q;
  assign ys     = y_q >>> iter_q;
  assign atan_z = Z_W'(ATAN_TURN[iter_q]);
  // dir high: add ys to x, subtract xs from y, add the table angle
  assign dir    = vec_q ? !y_q[VEC_W-1] : z_q[Z_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
      vec_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        iter_q <= '0;
        vec_q  <= ctl_i.vectoring;
        x_q    <= x0_i;
        y_q    <= y0_i;
        z_q    <= z0_i;
      end else if (busy_q) begin
        if (dir) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + atan_z;
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - atan_z;
        end
        iter_q <= iter_q + 1'b1;
        if (iter_q == ITER_W'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign done_o = done_q;

endmodule

// ===== sv/apg_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apg_mul
// Gain correction: a * INV_GAIN / 2^30, rounded half up, from two partial
// products, low half then high half, summed in a final step.
// ----------------------------------------------------------------------------
module apg_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [apg_pkg::VEC_W-1:0] a_i,
  output logic [apg_pkg::VEC_W-1:0] p_o,
  output logic                      done_o
);
  import apg_pkg::*;

  typedef enum logic [1:0] {M_IDLE, M_LO, M_HI, M_SUM} mstate_e;

  mstate_e          state_q;
  logic [VEC_W-1:0] a_q, p_q;
  logic [61:0]      lo_q;
  logic [49:0]      hi_q;
  logic             done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        M_IDLE: begin
          if (start_i) begin
            a_q     <= a_i;
            state_q <= M_LO;
          end
        end
        M_LO: begin
          lo_q    <= 62'(a_q[31:0] * INV_GAIN);
          state_q <= M_HI;
        end
        M_HI: begin
          hi_q    <= 50'(a_q[VEC_W-1:32] * INV_GAIN);
          state_q <= M_SUM;
        end
        M_SUM: begin
          p_q     <= VEC_W'({hi_q, 2'b00}) + VEC_W'((lo_q + 62'd536870912) >> 30);
          done_q  <= 1'b1;
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign p_o    = p_q;
  assign done_o = done_q;

endmodule

// ===== sv/apg_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apg_div
// Restoring divider, one quotient bit per cycle: sweep / (point count - 1).
// ----------------------------------------------------------------------------
module apg_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [apg_pkg::SWP_W-1:0] dividend_i,
  input  logic [apg_pkg::DIV_W-1:0] divisor_i,
  output logic [apg_pkg::SWP_W-1:0] quot_o,
  output logic [apg_pkg::DIV_W-1:0] rem_o,
  output logic                      done_o
);
  import apg_pkg::*;

  localparam int BIT_W = $clog2(SWP_W);

  logic [SWP_W-1:0] quot_q;
  logic [DIV_W-1:0] rem_q, dvs_q;
  logic [DIV_W:0]   trial;
  logic [BIT_W-1:0] bit_q;
  logic             busy_q, done_q, fits;

  assign trial = {rem_q, quot_q[SWP_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        bit_q  <= '0;
        quot_q <= dividend_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
      end else if (busy_q) begin
        // shift the dividend out of the top while quotient bits enter below
        rem_q  <= fits ? DIV_W'(trial - {1'b0, dvs_q}) : DIV_W'(trial);
        quot_q <= {quot_q[SWP_W-2:0], fits};
        bit_q  <= bit_q + 1'b1;
        if (bit_q == BIT_W'(SWP_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

// ===== sv/arc_point_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_point_generator
// Circular arc interpolation: emits evenly spaced points along an arc.
// ----------------------------------------------------------------------------
// Usage:
//   req_i : one arc request per transfer (start, end, centre, direction).
//   pt_o  : point_count points per arc, start point first, end point last
//           with last_point set; point_index counts from 0.
//   cfg_i : writes point_count (2..64, clamped); always ready, write only
//           between arcs.
// Sequence: one arc at a time. req_i is ready only when idle. The set-up
// takes two CORDIC vectoring passes, two gain corrections, a sweep
// division and a normalisation of the step; each middle point then takes
// one CORDIC rotation pass and an emit. The single iterative CORDIC unit
// serves every pass. The first point is offered once the set-up is done.
// Reset: point_count returns to 16, the sequencer idles, pt_o is empty.
// Stall: pt_o holds a point in an output register until it is taken; the
// sequencer waits on it and no point is dropped.
// ----------------------------------------------------------------------------
module arc_point_generator (
  input  logic      clk_i,
  input  logic      rst_ni,
  apg_req_if.sink   req_i,
  apg_pt_if.source  pt_o,
  apg_cfg_if.sink   cfg_i
);
  import apg_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_VEC1, S_VEC1_W, S_VEC2, S_VEC2_W, S_MUL1, S_MUL1_W, S_MUL2,
    S_MUL2_W, S_DIV, S_DIV_W, S_NORM, S_FIRST, S_ROT, S_ROT_W, S_EMIT, S_LAST
  } state_e;

  state_e state_q;

  // request and set-up registers
  logic signed [COORD_W-1:0] sx_q, sy_q, ex_q, ey_q, cx_q, cy_q;
  logic                      cw_q, flip_q;
  logic [CNT_W-1:0]          count_q, n_q, j_q;
  logic [ANG_W-1:0]          a1_q;
  logic [VEC_W-1:0]          mag_q;
  logic [SWP_W-1:0]          sweep_q, qs_q, q_q;
  logic [DIV_W-1:0]          rs_q;
  logic [CNT_W-1:0]          r_q;
  logic signed [COORD_W-1:0] px_q, py_q;

  // output register
  logic                      out_valid_q, out_last_q;
  logic signed [COORD_W-1:0] out_x_q, out_y_q;
  logic [IDX_W-1:0]          out_idx_q;
  logic                      out_free, emit;

  // arithmetic units; the CORDIC and the multiplier are shared
  cordic_ctl_t             cor_ctl;
  logic signed [VEC_W-1:0] cor_x0, cor_y0, cor_x, cor_y;
  logic signed [Z_W-1:0]   cor_z0, cor_z;
  logic                    cor_done, mul_start, mul_done, div_start, div_done;
  logic [VEC_W-1:0]        mul_a, mul_p;
  logic [SWP_W-1:0]        div_q;
  logic [DIV_W-1:0]        div_r, dvs;

  // set-up arithmetic
  logic signed [COORD_W:0]   dx, dy;
  logic signed [VEC_W-1:0]   gx, gy;
  logic [ANG_W-1:0]          ang, ang_r, diff;
  logic                      flip;
  logic [CNT_W-1:0]          n_clamp, r_norm, r_next;
  logic signed [COORD_W-1:0] place_x, place_y;

  assign out_free = !out_valid_q || pt_o.ready;
  assign emit     = out_free && ((state_q == S_FIRST) || (state_q == S_EMIT) ||
                                 (state_q == S_LAST));
  assign dvs      = DIV_W'(n_q - 1'b1);

  // clamp the register to the supported range
  always_comb begin
    n_clamp = count_q;
    if (count_q < CNT_W'(2))          n_clamp = CNT_W'(2);
    if (count_q > CNT_W'(MAX_POINTS)) n_clamp = CNT_W'(MAX_POINTS);
  end

  // vectoring start: difference to the centre, 16 guard bits, folded into
  // the right half-plane
  always_comb begin
    if (state_q == S_VEC2) begin
      dx = {ex_q[COORD_W-1], ex_q} - {cx_q[COORD_W-1], cx_q};
      dy = {ey_q[COORD_W-1], ey_q} - {cy_q[COORD_W-1], cy_q};
    end else begin
      dx = {sx_q[COORD_W-1], sx_q} - {cx_q[COORD_W-1], cx_q};
      dy = {sy_q[COORD_W-1], sy_q} - {cy_q[COORD_W-1], cy_q};
    end
    gx = VEC_W'(signed'({dx, 16'b0}));
    gy = VEC_W'(signed'({dy, 16'b0}));
  end

  // rotation angle of the current point, folded into [-90, 90) degrees
  assign ang   = cw_q ? a1_q - q_q[ANG_W-1:0] : a1_q + q_q[ANG_W-1:0];
  assign flip  = ang[ANG_W-1] ^ ang[ANG_W-2];
  assign ang_r = {ang[ANG_W-1] ^ flip, ang[ANG_W-2:0]};

  always_comb begin
    cor_ctl = '0;
    cor_x0  = gx;
    cor_y0  = gy;
    cor_z0  = '0;
    case (state_q)
      S_VEC1, S_VEC2: begin
        cor_ctl.start     = 1'b1;
        cor_ctl.vectoring = 1'b1;
        if (dx[COORD_W]) begin
          cor_x0 = -gx;
          cor_y0 = -gy;
          cor_z0 = Z_W'(34'h0_8000_0000);
        end
      end
      S_ROT: begin
        cor_ctl.start = 1'b1;
        cor_x0        = mag_q;
        cor_y0        = '0;
        cor_z0        = Z_W'(signed'(ang_r));
      end
      default: ;
    endcase
  end

  assign mul_start = (state_q == S_MUL1) || (state_q == S_MUL2);
  assign mul_a     = mag_q;
  assign div_start = (state_q == S_DIV);
  assign diff      = cw_q ? a1_q - cor_z[ANG_W-1:0] : cor_z[ANG_W-1:0] - a1_q;

  // place a rotated vector: round off the guard bits, add the centre, saturate
  function automatic logic signed [COORD_W-1:0] place(
    input logic signed [COORD_W-1:0] centre,
    input logic signed [VEC_W-1:0]   guarded
  );
    logic signed [VEC_W-1:0] rnd;
    logic signed [36:0]      sum;
    rnd = guarded + VEC_W'(32768);
    sum = 37'(centre) + 37'(signed'(rnd[VEC_W-1:16]));
    if (sum[36:31] == 6'b000000 || sum[36:31] == 6'b111111) begin
      place = sum[COORD_W-1:0];
    end else begin
      place = sum[36] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  endfunction

  assign place_x = place(cx_q, flip_q ? -cor_x : cor_x);
  assign place_y = place(cy_q, flip_q ? -cor_y : cor_y);

  // remainder of the first step, then of each later step
  assign r_norm = CNT_W'(rs_q) + CNT_W'(dvs >> 1);
  assign r_next = r_q + CNT_W'(rs_q);

  apg_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (cor_ctl),
    .x0_i   (cor_x0),
    .y0_i   (cor_y0),
    .z0_i   (cor_z0),
    .x_o    (cor_x),
    .y_o    (cor_y),
    .z_o    (cor_z),
    .done_o (cor_done)
  );

  apg_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .p_o     (mul_p),
    .done_o  (mul_done)
  );

  apg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sweep_q),
    .divisor_i  (dvs),
    .quot_o     (div_q),
    .rem_o      (div_r),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= POINT_COUNT_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        count_q <= cfg_i.data;
      end
      // load a new point, or drop the one just taken
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pt_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            sx_q    <= req_i.start_x;
            sy_q    <= req_i.start_y;
            ex_q    <= req_i.end_x;
            ey_q    <= req_i.end_y;
            cx_q    <= req_i.centre_x;
            cy_q    <= req_i.centre_y;
            cw_q    <= req_i.clockwise;
            n_q     <= n_clamp;
            state_q <= S_VEC1;
          end
        end
        S_VEC1:   state_q <= S_VEC1_W;
        S_VEC1_W: begin
          if (cor_done) begin
            a1_q    <= cor_z[ANG_W-1:0];
            mag_q   <= cor_x;
            state_q <= S_VEC2;
          end
        end
        S_VEC2:   state_q <= S_VEC2_W;
        S_VEC2_W: begin
          if (cor_done) begin
            // equal angles sweep a full turn
            sweep_q <= (diff == '0) ? {1'b1, {ANG_W{1'b0}}} : {1'b0, diff};
            state_q <= S_MUL1;
          end
        end
        S_MUL1:   state_q <= S_MUL1_W;
        S_MUL1_W: begin
          if (mul_done) begin
            mag_q   <= mul_p;   // radius with guard bits
            state_q <= S_MUL2;
          end
        end
        S_MUL2:   state_q <= S_MUL2_W;
        S_MUL2_W: begin
          if (mul_done) begin
            mag_q   <= mul_p;   // rotation start vector
            state_q <= S_DIV;
          end
        end
        S_DIV:    state_q <= S_DIV_W;
        S_DIV_W: begin
          if (div_done) begin
            qs_q    <= div_q;
            rs_q    <= div_r;
            state_q <= S_NORM;
          end
        end
        S_NORM: begin
          if (r_norm >= CNT_W'(dvs)) begin
            r_q <= r_norm - CNT_W'(dvs);
            q_q <= qs_q + 1'b1;
          end else begin
            r_q <= r_norm;
            q_q <= qs_q;
          end
          j_q     <= CNT_W'(1);
          state_q <= S_FIRST;
        end
        S_FIRST: begin
          if (out_free) begin
            out_x_q     <= sx_q;
            out_y_q     <= sy_q;
            out_idx_q   <= '0;
            out_last_q  <= 1'b0;
            state_q     <= (n_q == CNT_W'(2)) ? S_LAST : S_ROT;
          end
        end
        S_ROT: begin
          flip_q  <= flip;
          state_q <= S_ROT_W;
        end
        S_ROT_W: begin
          if (cor_done) begin
            px_q    <= place_x;
            py_q    <= place_y;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_x_q     <= px_q;
            out_y_q     <= py_q;
            out_idx_q   <= IDX_W'(j_q);
            out_last_q  <= 1'b0;
            // advance the step angle by sweep / (n - 1)
            if (r_next >= CNT_W'(dvs)) begin
              r_q <= r_next - CNT_W'(dvs);
              q_q <= q_q + qs_q + 1'b1;
            end else begin
              r_q <= r_next;
              q_q <= q_q + qs_q;
            end
            j_q     <= j_q + 1'b1;
            state_q <= (j_q + 1'b1 == n_q - 1'b1) ? S_LAST : S_ROT;
          end
        end
        S_LAST: begin
          if (out_free) begin
            out_x_q     <= ex_q;
            out_y_q     <= ey_q;
            out_idx_q   <= IDX_W'(n_q - 1'b1);
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign req_i.ready      = (state_q == S_IDLE);
  assign cfg_i.ready      = 1'b1;
  assign pt_o.valid       = out_valid_q;
  assign pt_o.point_x     = out_x_q;
  assign pt_o.point_y     = out_y_q;
  assign pt_o.point_index = out_idx_q;
  assign pt_o.last_point  = out_last_q;

endmodule

// ===== sv/apg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apg_checker
// Port-level checks on the arc point generator, bound to the top level.
// ----------------------------------------------------------------------------
module apg_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       pt_valid_i,
  input logic       pt_ready_i,
  input logic [5:0] pt_index_i,
  input logic       pt_last_i,
  input logic       cfg_valid_i,
  input logic       cfg_ready_i
);

  // one arc at a time: no new request straight after a transfer
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while an arc is in progress");

  // an arc always has at least two points
  a_last_not_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_valid_i && pt_last_i |-> pt_index_i != 6'd0)
    else $error("last point carries index zero");

  // hold a stalled point
  a_pt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_valid_i && !pt_ready_i |=> pt_valid_i && $stable(pt_index_i))
    else $error("stalled point dropped or changed");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("register write refused");

endmodule

bind arc_point_generator apg_checker u_apg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .pt_valid_i  (pt_o.valid),
  .pt_ready_i  (pt_o.ready),
  .pt_index_i  (pt_o.point_index),
  .pt_last_i   (pt_o.last_point),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready)
);
